// ===== src/bpq_pkg.sv =====
// Shared types and constants for the bounded priority queue.
`default_nettype none
package bpq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRI_W    = 4;
	localparam int PAY_W    = 32;
	localparam int OCC_W    = 7;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Command broadcast to every cell of the row in the cycle of an operation.
	typedef struct packed {
		logic             enq;
		logic             deq;
		logic             serve_low_first;
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] pay;
	} cmd_t;

endpackage
`default_nettype wire

// ===== src/bounded_priority_queue.sv =====
// Bounded priority queue built as a row of shifting cells.
//
// Input stream (s_*): one transaction is one operation. s_tuser selects it
// (0 enqueue, 1 dequeue); s_tdata carries the priority and payload to enqueue.
// Output stream (m_*): exactly one result transaction per operation, with the
// status in m_tuser and the dequeued entry and the occupancy in m_tdata.
// Configuration (cfg_*): cfg_data sets the service order, 1 = smaller priority
// first, 0 = larger first. Write it only while the queue is idle.
//
// Every cell compares the new priority with its own entry at once: the result
// is registered and shows on m_tvalid the cycle after acceptance, and one
// operation can be taken every cycle while the receiver takes the results.
// When the receiver stalls, the result register holds and s_tready drops
// until it is taken. Equal priorities leave in arrival order.
// Reset empties the queue and sets smaller-priority-first; the cells' contents
// are not cleared, as only occupied cells are ever read.
`default_nettype none
module bounded_priority_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // in_priority[3:0], in_payload[35:4], zero pad
	input  wire logic [0:0]  s_tuser,  // func[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // out_priority[3:0], out_payload[35:4],
	                                   // occupancy[42:36], zero pad
	output logic [1:0]       m_tuser,  // status[1:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);
	import bpq_pkg::*;

	logic             serve_low_first_q;
	logic [CNT_W-1:0] count_q;
	logic             m_tvalid_q;
	status_t          status_q;
	logic [PRI_W-1:0] out_pri_q;
	logic [PAY_W-1:0] out_pay_q;
	logic [OCC_W-1:0] occ_q;

	logic             accept;
	logic             is_enq;
	logic             enq_ok;
	logic             deq_ok;
	logic [CNT_W-1:0] count_next;
	cmd_t             cmd;

	logic             place   [CAPACITY];
	logic [PRI_W-1:0] cell_pri[CAPACITY];
	logic [PAY_W-1:0] cell_pay[CAPACITY];

	assign s_tready  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign is_enq = (s_tuser[0] == FUNC_ENQ);
	assign enq_ok = accept && is_enq && (count_q < CNT_W'(CAPACITY));
	assign deq_ok = accept && !is_enq && (count_q != '0);

	always_comb begin
		count_next = count_q;
		if (enq_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (deq_ok) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign cmd.enq             = enq_ok;
	assign cmd.deq             = deq_ok;
	assign cmd.serve_low_first = serve_low_first_q;
	assign cmd.pri             = s_tdata[PRI_W-1:0];
	assign cmd.pay             = s_tdata[PRI_W+PAY_W-1:PRI_W];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             lp;
		logic [PRI_W-1:0] lpri;
		logic [PAY_W-1:0] lpay;
		logic [PRI_W-1:0] rpri;
		logic [PAY_W-1:0] rpay;

		if (i == 0) begin : g_head
			assign lp   = 1'b0;
			assign lpri = cmd.pri;
			assign lpay = cmd.pay;
		end else begin : g_body
			assign lp   = place[i-1];
			assign lpri = cell_pri[i-1];
			assign lpay = cell_pay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rpri = cell_pri[i];
			assign rpay = cell_pay[i];
		end else begin : g_inner
			assign rpri = cell_pri[i+1];
			assign rpay = cell_pay[i+1];
		end

		bpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (CNT_W'(i) < count_q),
			.left_place (lp),
			.left_pri   (lpri),
			.left_pay   (lpay),
			.right_pri  (rpri),
			.right_pay  (rpay),
			.place      (place[i]),
			.pri        (cell_pri[i]),
			.pay        (cell_pay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serve_low_first_q <= 1'b1;
			count_q           <= '0;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				serve_low_first_q <= cfg_data;
			end
			count_q <= count_next;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_enq) begin
				status_q <= enq_ok ? ST_OK : ST_FULL;
			end else begin
				status_q <= deq_ok ? ST_OK : ST_EMPTY;
			end
			out_pri_q <= deq_ok ? cell_pri[0] : '0;
			out_pay_q <= deq_ok ? cell_pay[0] : '0;
			occ_q     <= OCC_W'(count_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'd0, occ_q, out_pay_q, out_pri_q};

endmodule
`default_nettype wire

// ===== src/bpq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts toward either neighbor.
`default_nettype none
module bpq_cell (
	input  wire logic                      clk,
	input  wire bpq_pkg::cmd_t             cmd,
	input  wire logic                      occupied,
	input  wire logic                      left_place,
	input  wire logic [bpq_pkg::PRI_W-1:0] left_pri,
	input  wire logic [bpq_pkg::PAY_W-1:0] left_pay,
	input  wire logic [bpq_pkg::PRI_W-1:0] right_pri,
	input  wire logic [bpq_pkg::PAY_W-1:0] right_pay,
	output logic                           place,
	output logic [bpq_pkg::PRI_W-1:0]      pri,
	output logic [bpq_pkg::PAY_W-1:0]      pay
);
	import bpq_pkg::*;

	logic             beats;
	logic [PRI_W-1:0] pri_q;
	logic [PAY_W-1:0] pay_q;

	assign beats = cmd.serve_low_first ? (cmd.pri < pri_q) : (cmd.pri > pri_q);
	// Place is carried down the row, so it is false before the insertion point and true from
	// it onward even when a change of service order has left the row unsorted.
	assign place = left_place || !occupied || beats;
	assign pri   = pri_q;
	assign pay   = pay_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (left_place) begin
				pri_q <= left_pri;
				pay_q <= left_pay;
			end else if (place) begin
				pri_q <= cmd.pri;
				pay_q <= cmd.pay;
			end
		end else if (cmd.deq) begin
			pri_q <= right_pri;
			pay_q <= right_pay;
		end
	end

endmodule
`default_nettype wire

// ===== src/bpq_checker.sv =====
// Port-level checks for the bounded priority queue, bound to the top level.
`default_nettype none
module bpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import bpq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_FULL) || (m_tuser == ST_EMPTY))
		else $error("undefined status code");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[42:36] <= OCC_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata == 48'd0)
		else $error("empty result carries data");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |->
			(m_tdata[42:36] == OCC_W'(CAPACITY)) && (m_tdata[35:0] == 36'd0))
		else $error("full result with wrong occupancy or data");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the bounded priority queue with a shadow sorted store.
`default_nettype none
module tb_top;
	import bpq_pkg::*;

	typedef struct {
		logic             func;
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] pay;
	} op_t;

	typedef struct {
		status_t          status;
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] pay;
		logic [OCC_W-1:0] occ;
	} reply_t;

	typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN, SAWTOOTH} mix_t;

	localparam int LONG_HOLD = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;  // in_priority[3:0], in_payload[35:4], zero pad
	logic [0:0]  s_tuser   = '0;  // func[0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;         // out_priority[3:0], out_payload[35:4], occupancy[42:36]
	logic [1:0]  m_tuser;         // status[1:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b1;

	op_t    pending_ops[$];
	reply_t op_replies[$];
	reply_t want;
	int     mismatch_count = 0;

	// Shadow copy of the sorted store, slot 0 is the head.
	logic [PRI_W-1:0] shadow_pri [CAPACITY];
	logic [PAY_W-1:0] shadow_pay [CAPACITY];
	int               shadow_count = 0;
	logic             shadow_low_first = 1'b1;

	// Sender and receiver pacing state.
	int burst_left = 0;
	int gap_left = 0;
	bit no_gaps = 1'b0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_done = 0;

	bounded_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one operation to the shadow store and returns the reply it must produce.
	function automatic reply_t compute_reply(logic func, logic [PRI_W-1:0] pri,
			logic [PAY_W-1:0] pay);
		reply_t r;
		int pos;
		bit found;
		r.status = ST_OK;
		r.pri = '0;
		r.pay = '0;
		if (func == FUNC_ENQ) begin
			if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = shadow_count;
				found = 1'b0;
				// The new entry goes ahead of the first one it strictly beats.
				for (int i = 0; i < shadow_count; i++) begin
					if (!found && (shadow_low_first ? pri < shadow_pri[i]
							: pri > shadow_pri[i])) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (int i = shadow_count; i > pos; i--) begin
					shadow_pri[i] = shadow_pri[i-1];
					shadow_pay[i] = shadow_pay[i-1];
				end
				shadow_pri[pos] = pri;
				shadow_pay[pos] = pay;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.pri = shadow_pri[0];
				r.pay = shadow_pay[0];
				for (int i = 1; i < shadow_count; i++) begin
					shadow_pri[i-1] = shadow_pri[i];
					shadow_pay[i-1] = shadow_pay[i];
				end
				shadow_count--;
			end
		end
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	task automatic add_op(input logic func, input logic [PRI_W-1:0] pri,
			input logic [PAY_W-1:0] pay);
		op_t op;
		op.func = func;
		op.pri = pri;
		op.pay = pay;
		pending_ops.push_back(op);
	endtask

	task automatic write_order(input logic low_first);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= low_first;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || op_replies.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(pending_ops.pop_front());
				if (burst_left > 0)
					burst_left--;
			end
			if (!s_tvalid || s_tready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = no_gaps ? 0 : $urandom_range(0, 8);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, pending_ops[0].pay, pending_ops[0].pri};
					s_tuser <= pending_ops[0].func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a randomly chosen stall pattern, plus requested long holds.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		if (holds_done != hold_requests) begin
			holds_done++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_cycle % 3 != 0);
			endcase
		end
	end

	// Monitor: checks replies first, since a reply never belongs to an operation
	// accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (op_replies.size() == 0) begin
					$error("reply transaction with no operation awaiting it");
					mismatch_count++;
				end else begin
					want = op_replies.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						mismatch_count++;
					end
					if (m_tdata[3:0] !== want.pri) begin
						$error("out_priority: expected %0d, got %0d", want.pri, m_tdata[3:0]);
						mismatch_count++;
					end
					if (m_tdata[35:4] !== want.pay) begin
						$error("out_payload: expected %h, got %h", want.pay, m_tdata[35:4]);
						mismatch_count++;
					end
					if (m_tdata[42:36] !== want.occ) begin
						$error("occupancy: expected %0d, got %0d", want.occ, m_tdata[42:36]);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_low_first = cfg_data;
			if (s_tvalid && s_tready)
				op_replies.push_back(compute_reply(s_tuser[0], s_tdata[3:0], s_tdata[35:4]));
		end
	end

	initial begin
		mix_t mix;
		logic func;
		logic [PRI_W-1:0] pri;
		int gen_held;
		int overflow;
		int sel;
		int tie_base;
		int enq_pct;
		bit filling;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_order(1'b1);

		// Directed: empty dequeue, extreme fields, ties in both service orders.
		for (int rep = 0; rep < 2; rep++) begin
			if (rep == 1) begin
				wait_idle();
				write_order(1'b0);
			end
			@(negedge clk);
			add_op(FUNC_DEQ, 4'hF, 32'hFFFF_FFFF);
			add_op(FUNC_ENQ, 4'h0, 32'h0000_0000);
			add_op(FUNC_ENQ, 4'hF, 32'hFFFF_FFFF);
			add_op(FUNC_ENQ, 4'h7, 32'hA5A5_A5A5);
			add_op(FUNC_ENQ, 4'h7, 32'h5A5A_5A5A);
			add_op(FUNC_ENQ, 4'h0, 32'h0000_0001);
			repeat (6) add_op(FUNC_DEQ, PRI_W'($urandom), $urandom);
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_order(1'(ph % 2));
			@(negedge clk);
			mix = mix_t'((ph + 3) % 4);
			no_gaps = (ph == 2);
			enq_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 30 : 50;
			tie_base = $urandom_range(0, 14);
			gen_held = 0;
			overflow = 0;
			filling = 1'b1;
			for (int k = 0; k < 140; k++) begin
				if (mix == SAWTOOTH) begin
					// Fill to two overflows, then drain to two empty dequeues.
					func = filling ? FUNC_ENQ : FUNC_DEQ;
					if ((filling && gen_held == CAPACITY) || (!filling && gen_held == 0)) begin
						overflow++;
						if (overflow == 2) begin
							filling = !filling;
							overflow = 0;
						end
					end
				end else begin
					func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				end
				if (func == FUNC_ENQ && gen_held < CAPACITY)
					gen_held++;
				else if (func == FUNC_DEQ && gen_held > 0)
					gen_held--;
				sel = $urandom_range(0, 9);
				if (sel < 5)
					pri = PRI_W'($urandom_range(0, 15));
				else if (sel < 8)
					pri = PRI_W'(tie_base + $urandom_range(0, 1));
				else
					pri = $urandom_range(0, 1) ? 4'hF : 4'h0;
				add_op(func, pri, $urandom);
			end
			// A long receiver hold while the sender keeps offering operations.
			if (ph == 1 || ph == 4)
				hold_requests++;
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("bounded_priority_queue verification clean");
		else
			$display("bounded_priority_queue verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("bounded_priority_queue verification failed");
		$finish;
	end

endmodule
`default_nettype wire
